// ===== hw/rtl/swdf_pkg.sv =====
`timescale 1ns / 1ps

package swdf_pkg;

   // payload widths
   localparam int BYTE_W = 8;
   localparam int POS_W  = 4;

   // configuration port
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_FIRST  = 2'd0,
      CSR_SYNC_SECOND = 2'd1
   } csr_index_type;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hEB;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h90;

endpackage

// ===== hw/rtl/swdf_cell.sv =====
`timescale 1ns / 1ps

// One byte slot of the frame chain; takes its neighbor's byte on each shift.
module swdf_cell (
   input  logic                          clock,
   input  logic                          shift,
   input  logic [swdf_pkg::BYTE_W-1:0]   d_in,
   output logic [swdf_pkg::BYTE_W-1:0]   q
);

   logic [swdf_pkg::BYTE_W-1:0] data_ff;
   logic [swdf_pkg::BYTE_W-1:0] data_in;

   // hold unless the chain moves
   always_comb begin
      data_in = shift ? d_in : data_ff;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

// ===== hw/rtl/swdf_ctrl.sv =====
`timescale 1ns / 1ps

// Sync hunt, fill count, running checksum and replay sequencing.
module swdf_ctrl #(
   parameter int FRAME_BYTES = 11
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [swdf_pkg::BYTE_W-1:0]     req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [swdf_pkg::POS_W-1:0]      rsp_byte_position,
   output logic                            rsp_last,
   input  logic                            csr_write_en,
   input  logic [swdf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [swdf_pkg::BYTE_W-1:0]     csr_write_data,
   output logic                            shift_en
);

   localparam int CW = $clog2(FRAME_BYTES);
   localparam int PW = (CW > swdf_pkg::POS_W) ? CW : swdf_pkg::POS_W;
   localparam logic [CW-1:0] FILL_LAST = CW'(FRAME_BYTES - 1);
   localparam logic [PW-1:0] POS_LAST  = PW'(FRAME_BYTES - 1);

   typedef enum logic {
      ST_COLLECT,
      ST_REPLAY
   } state_type;

   state_type                   state_ff, state_in;
   logic [CW-1:0]               fill_ff, fill_in;
   logic [swdf_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic [PW-1:0]               pos_ff, pos_in;
   logic [swdf_pkg::BYTE_W-1:0] sync_first_ff, sync_first_in;
   logic [swdf_pkg::BYTE_W-1:0] sync_second_ff, sync_second_in;

   // register writes; unknown indexes are ignored
   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      if (csr_write_en) begin
         case (csr_index)
            swdf_pkg::CSR_SYNC_FIRST:  sync_first_in  = csr_write_data;
            swdf_pkg::CSR_SYNC_SECOND: sync_second_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // hunt / collect / replay
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      sum_in   = sum_ff;
      pos_in   = pos_ff;
      shift_en = 1'b0;
      case (state_ff)
         ST_COLLECT: begin
            if (req_valid) begin
               if (fill_ff == '0) begin
                  if (req_rx_byte == sync_first_ff) begin
                     shift_en = 1'b1;
                     fill_in  = CW'(1);
                     sum_in   = req_rx_byte;
                  end
               end else if (fill_ff == CW'(1)) begin
                  if (req_rx_byte == sync_second_ff) begin
                     shift_en = 1'b1;
                     fill_in  = CW'(2);
                     sum_in   = sum_ff + req_rx_byte;
                  end else begin
                     fill_in = '0;
                     sum_in  = '0;
                  end
               end else if (fill_ff != FILL_LAST) begin
                  shift_en = 1'b1;
                  fill_in  = fill_ff + CW'(1);
                  sum_in   = sum_ff + req_rx_byte;
               end else begin
                  // final byte carries the checksum
                  fill_in = '0;
                  sum_in  = '0;
                  if (req_rx_byte == sum_ff) begin
                     shift_en = 1'b1;
                     pos_in   = '0;
                     state_in = ST_REPLAY;
                  end
               end
            end
         end
         ST_REPLAY: begin
            if (rsp_ready) begin
               shift_en = 1'b1;
               pos_in   = pos_ff + PW'(1);
               if (pos_ff == POS_LAST) begin
                  state_in = ST_COLLECT;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_COLLECT;
         fill_ff        <= '0;
         sum_ff         <= '0;
         pos_ff         <= '0;
         sync_first_ff  <= swdf_pkg::SYNC_FIRST_RST;
         sync_second_ff <= swdf_pkg::SYNC_SECOND_RST;
      end else begin
         state_ff       <= state_in;
         fill_ff        <= fill_in;
         sum_ff         <= sum_in;
         pos_ff         <= pos_in;
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
      end
   end

   assign req_ready         = (state_ff == ST_COLLECT);
   assign rsp_valid         = (state_ff == ST_REPLAY);
   assign rsp_byte_position = pos_ff[swdf_pkg::POS_W-1:0];
   assign rsp_last          = (state_ff == ST_REPLAY) && (pos_ff == POS_LAST);

endmodule

// ===== hw/rtl/sync_word_frame_deframer_sum_check_top.sv =====
`timescale 1ns / 1ps
// Latency: the first beat of a good frame shows the cycle after its checksum
//   byte is accepted; dropped bytes and bad frames give no beats.
// Throughput: one byte per cycle while collecting, then FRAME_BYTES replay beats
//   from the head of the cell chain with input held off.
// Reset: synchronous; clears hunt state, checksum and replay; sync bytes return
//   to 0xEB / 0x90. Frame cells are not reset.
module sync_word_frame_deframer_sum_check_top #(
   parameter int FRAME_BYTES = 11
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [swdf_pkg::BYTE_W-1:0]     req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [swdf_pkg::BYTE_W-1:0]     rsp_frame_byte,
   output logic [swdf_pkg::POS_W-1:0]      rsp_byte_position,
   output logic                            rsp_last,
   input  logic                            csr_write_en,
   input  logic [swdf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [swdf_pkg::BYTE_W-1:0]     csr_write_data
);

   logic                        shift_en;
   logic [swdf_pkg::BYTE_W-1:0] cell_q [FRAME_BYTES];

   swdf_ctrl #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last          (rsp_last),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .shift_en          (shift_en)
   );

   // byte chain: enters at the tail, leaves from cell 0
   for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
      if (i == FRAME_BYTES - 1) begin : g_tail
         swdf_cell u_cell (
            .clock (clock),
            .shift (shift_en),
            .d_in  (req_rx_byte),
            .q     (cell_q[i])
         );
      end else begin : g_body
         swdf_cell u_cell (
            .clock (clock),
            .shift (shift_en),
            .d_in  (cell_q[i+1]),
            .q     (cell_q[i])
         );
      end
   end

   assign rsp_frame_byte = cell_q[0];

endmodule

// ===== hw/rtl/swdf_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks on the deframer.
module swdf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [swdf_pkg::BYTE_W-1:0]     rsp_frame_byte,
   input logic [swdf_pkg::POS_W-1:0]      rsp_byte_position,
   input logic                            rsp_last
);

   // no byte is taken while a frame replays
   a_no_input_in_replay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input accepted during replay");

   // a stalled beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_byte)
         && $stable(rsp_byte_position) && $stable(rsp_last))
      else $error("stalled beat changed");

   // positions step by one inside a frame run
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid
         && rsp_byte_position == swdf_pkg::POS_W'($past(rsp_byte_position) + 1))
      else $error("frame run broke or skipped a position");

   // run ends right after its last beat
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("beat after last");

   // a run starts at position zero
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_byte_position == '0)
      else $error("frame run did not start at zero");

endmodule

bind sync_word_frame_deframer_sum_check_top swdf_checker u_swdf_checker (.*);
